// ----- hw/rtl/rgbds_pkg.sv -----
// Package for the weighted 4x4 RGB downscaler: sizes, word types and the
// 3,5,5,3 tap multipliers. Depends on nothing; used by the core.
`default_nettype none

package rgbds_pkg;

  // Output frame size in pixels
  localparam int OUT_WIDTH  = 40;
  localparam int OUT_HEIGHT = 36;

  // Source pixels used per line, and line length after reset
  localparam int USED_PIXELS = 4 * OUT_WIDTH;
  localparam int LINE_W      = 12;
  localparam int LEN_RESET   = 160;

  // Counter and index widths
  localparam int COL_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int ROW_W = $clog2(OUT_HEIGHT + 1);

  // Accumulator widths: a line of one block is at most 16*255,
  // a full block at most 256*255
  localparam int ACC_W  = 12;
  localparam int PART_W = 16;
  localparam int ENTRY_W = 3 * PART_W;

  typedef struct packed {
    logic [23:0] pixel;
    logic        frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [23:0] out_pixel;
    logic        last_of_frame;
  } pix_out_t;

  // Tap weight is 5 for the middle two phases, 3 for the outer two
  function automatic logic [ACC_W-1:0] h_tap(input logic [7:0] v, input logic [1:0] ph);
    logic [ACC_W-1:0] w;
    begin
      w = ACC_W'(v);
      if (ph == 2'd1 || ph == 2'd2) begin
        h_tap = w + (w << 2);
      end else begin
        h_tap = w + (w << 1);
      end
    end
  endfunction

  function automatic logic [PART_W-1:0] v_tap(input logic [ACC_W-1:0] v,
                                              input logic [1:0] ph);
    logic [PART_W-1:0] w;
    begin
      w = PART_W'(v);
      if (ph == 2'd1 || ph == 2'd2) begin
        v_tap = w + (w << 2);
      end else begin
        v_tap = w + (w << 1);
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rgb_downscale_4x4_weighted_core.sv -----
// Weighted 4x4 box downscaler for RGB888 video, top level.
// Depends on rgbds_pkg for sizes, word types and tap multipliers.
`default_nettype none

// Takes one source pixel word per clock in raster order and gives one output
// word per 4x4 block, on the block's last pixel, weighted 3,5,5,3 both ways.
// Throughput is one input word per clock; in_stall rises only while a result
// word sits in the output register and out_stall holds it. Per-column partial
// sums of the current block row live in a 40 x 48 bit synchronous RAM: the
// entry for a column is read when the column's first pixel of a line arrives
// and written back on its fourth; a result word is registered from the
// word that completes the block. line_length below 4*OUT_WIDTH is clamped up;
// pixels beyond the used width and lines beyond the used height are dropped.
// in_data.frame_start restarts the position on that word.
module rgb_downscale_4x4_weighted_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  rgbds_pkg::pix_in_t         in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output rgbds_pkg::pix_out_t        out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [rgbds_pkg::LINE_W-1:0] cfg_data
);

  localparam int LW = rgbds_pkg::LINE_W;
  localparam int CW = rgbds_pkg::COL_W;
  localparam int RW = rgbds_pkg::ROW_W;
  localparam int AW = rgbds_pkg::ACC_W;
  localparam int PW = rgbds_pkg::PART_W;
  localparam int EW = rgbds_pkg::ENTRY_W;

  // Registers
  logic [LW-1:0] line_length_r;
  logic [LW-1:0] x_r, x_nxt;
  logic [1:0]    row_phase_r, row_phase_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [AW-1:0] acc_r [3];
  logic [AW-1:0] acc_nxt [3];
  logic          out_valid_r, out_valid_nxt;
  rgbds_pkg::pix_out_t out_data_r, out_data_nxt;

  // Column partial RAM
  logic [EW-1:0] col_mem [rgbds_pkg::OUT_WIDTH];
  logic [EW-1:0] rd_data_r;
  logic [EW-1:0] wr_data;
  logic          rd_en, wr_en;

  // Decoded position of the accepted word
  logic          accept;
  logic [LW-1:0] x_eff;
  logic [1:0]    rp_eff;
  logic [RW-1:0] row_eff;
  logic [AW-1:0] acc_eff [3];
  logic [LW:0]   x_inc;
  logic [LW-1:0] len_eff;
  logic          active, wrap;
  logic [1:0]    ph;
  logic [CW-1:0] col;
  logic [AW-1:0] acc_sum [3];
  logic [PW-1:0] part_sum [3];
  logic [7:0]    chan [3];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Position after an optional frame restart
  always_comb begin
    x_eff   = in_data.frame_start ? '0 : x_r;
    rp_eff  = in_data.frame_start ? '0 : row_phase_r;
    row_eff = in_data.frame_start ? '0 : out_row_r;
    for (int c = 0; c < 3; c++) begin
      acc_eff[c] = in_data.frame_start ? '0 : acc_r[c];
    end
    len_eff = (line_length_r < LW'(rgbds_pkg::USED_PIXELS)) ?
              LW'(rgbds_pkg::USED_PIXELS) : line_length_r;
    x_inc   = {1'b0, x_eff} + 1'b1;
    wrap    = x_inc >= {1'b0, len_eff};
    active  = (row_eff < RW'(rgbds_pkg::OUT_HEIGHT)) &&
              (x_eff < LW'(rgbds_pkg::USED_PIXELS));
    ph      = x_eff[1:0];
    col     = x_eff[CW+1:2];
    chan[0] = in_data.pixel[23:16];
    chan[1] = in_data.pixel[15:8];
    chan[2] = in_data.pixel[7:0];
  end

  // Horizontal and vertical weighting, read-modify-write of the column entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_sum[c]  = acc_eff[c] + rgbds_pkg::h_tap(chan[c], ph);
      part_sum[c] = rgbds_pkg::v_tap(acc_sum[c], rp_eff);
      if (rp_eff != 2'd0) begin
        part_sum[c] = part_sum[c] + rd_data_r[(2-c)*PW +: PW];
      end
    end
    wr_data = {part_sum[0], part_sum[1], part_sum[2]};
    rd_en   = accept & active & (ph == 2'd0);
    wr_en   = accept & active & (ph == 2'd3);
  end

  // Next state of position, accumulators and output register
  always_comb begin
    x_nxt         = x_r;
    row_phase_nxt = row_phase_r;
    out_row_nxt   = out_row_r;
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = acc_r[c];
    end
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) begin
      for (int c = 0; c < 3; c++) begin
        if (active && ph != 2'd3) begin
          acc_nxt[c] = acc_sum[c];
        end else if (active) begin
          acc_nxt[c] = '0;
        end else begin
          acc_nxt[c] = acc_eff[c];
        end
      end
      if (wrap) begin
        x_nxt         = '0;
        row_phase_nxt = rp_eff + 2'd1;
        for (int c = 0; c < 3; c++) begin
          acc_nxt[c] = '0;
        end
        if (rp_eff == 2'd3 && row_eff < RW'(rgbds_pkg::OUT_HEIGHT)) begin
          out_row_nxt = row_eff + 1'b1;
        end else begin
          out_row_nxt = row_eff;
        end
      end else begin
        x_nxt         = x_inc[LW-1:0];
        row_phase_nxt = rp_eff;
        out_row_nxt   = row_eff;
      end
      // Result word on the last pixel of a block
      if (wr_en && rp_eff == 2'd3) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.out_pixel = {part_sum[0][15:8], part_sum[1][15:8], part_sum[2][15:8]};
        out_data_nxt.last_of_frame =
          (row_eff == RW'(rgbds_pkg::OUT_HEIGHT - 1)) &&
          (col == CW'(rgbds_pkg::OUT_WIDTH - 1));
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LW'(rgbds_pkg::LEN_RESET);
      x_r           <= '0;
      row_phase_r   <= '0;
      out_row_r     <= '0;
      out_valid_r   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_length_r <= cfg_data;
      end
      x_r         <= x_nxt;
      row_phase_r <= row_phase_nxt;
      out_row_r   <= out_row_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Column RAM: read on a column's first pixel, write back on its fourth
  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[col] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= col_mem[col];
    end
  end

endmodule

`default_nettype wire
